[hdl/gei_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gei_pkg: shared constants for the gyro Euler angle integrator
// Stream widths, register indexes, sine polynomial and rate scale constants.
// ----------------------------------------------------------------------------
package gei_pkg;

    localparam int ANGLE_BITS_DEF = 32;

    localparam int IN_W       = 64;
    localparam int OUT_W      = 96;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X = 8'd0,
        CFG_OFFSET_Y = 8'd1,
        CFG_OFFSET_Z = 8'd2,
        CFG_DEADBAND = 8'd3
    } cfg_index_t;

    localparam logic [19:0] DEADBAND_RST = 20'd17089;

    // count * us to turns, scaled by 2^67
    localparam logic [31:0] RATE_MUL = 32'd3129218672;

    // odd sine polynomial, Q30
    localparam logic [30:0] PC1 = 31'd1686629713;
    localparam logic [30:0] PC3 = 31'd693598668;
    localparam logic [30:0] PC5 = 31'd85569306;
    localparam logic [30:0] PC7 = 31'd5026995;
    localparam logic [31:0] PC9 = 32'd172273;

    // secant saturation: 4096.0 in Q16
    localparam logic [29:0] SEC_MAX   = 30'd268435456;
    localparam logic [16:0] COS_SMALL = 17'd16;

    // Horner term that the product of sub-step k is subtracted from
    function automatic logic [30:0] sin_coef(input logic [2:0] k);
        logic [30:0] c;
        case (k)
            3'd1:    c = PC7;
            3'd2:    c = PC5;
            3'd3:    c = PC3;
            default: c = PC1;
        endcase
        return c;
    endfunction

endpackage

[hdl/gyro_euler_angle_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_euler_angle_integrator: rate gyro attitude propagation
// One shared 64x16 multiplier and a bit-serial divider under a sequencer
// turn a gyro sample into roll, pitch and yaw increments added to the angles.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: rate_x, rate_y, rate_z, elapsed_us
//  m_      | out | m_tvalid/m_tready  | m_tdata: roll, pitch, yaw
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Of the 37 products on the shared multiplier, 24 go to the four sine
//  evaluations; each product takes a low and a high half pass, and a
//  bit-serial divider forms the secant unless the cosine of pitch is near
//  zero, where the secant saturates instead.
//  s_tready is high only while the sequencer is idle; a result waiting on
//  m_tready does not block the next transaction until it must be replaced.
//  Synchronous active-low reset clears angles, offsets and control state and restores the deadband default.
// ----------------------------------------------------------------------------
module gyro_euler_angle_integrator #(
    parameter int ANGLE_BITS = gei_pkg::ANGLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // rate_x[15:0], rate_y[31:16], rate_z[47:32], elapsed_us[63:48]
    input  logic [gei_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // roll[31:0], pitch[63:32], yaw[95:64]
    output logic [gei_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gei_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gei_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gei_pkg::*;

    localparam int RATE_SHIFT = 67 - ANGLE_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_W, ST_SIN, ST_DIV, ST_TAN, ST_QR, ST_QT, ST_QS, ST_SCALE, ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [1:0]              idx_reg;
    logic [2:0]              sub_reg;
    logic                    half_reg;
    logic [5:0]              cnt_reg;
    logic [95:0]             acc_reg;

    logic signed [15:0]      off_reg [3];
    logic [19:0]             deadband_reg;
    logic signed [16:0]      diff_reg [3];
    logic [15:0]             dt_reg;
    logic signed [33:0]      w_reg [3];
    logic [30:0]             z2_reg;
    logic [30:0]             p_reg;
    logic signed [17:0]      sin_reg [4];
    logic [16:0]             rem_reg;
    logic [28:0]             quo_reg;
    logic signed [29:0]      sec_reg;
    logic signed [29:0]      tn_reg;
    logic signed [51:0]      q_reg;
    logic signed [51:0]      r_reg;
    logic signed [47:0]      d_reg [3];
    logic [ANGLE_BITS-1:0]   att_reg [3];
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        m_tdata_reg;

    // binary angles seen at 32 bits
    logic [31:0]             bam [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bam[i] = 32'({att_reg[i], 32'b0} >> ANGLE_BITS);
        end
    end

    // sine argument: roll, roll + 90deg, pitch, pitch + 90deg
    logic [31:0] sin_ang;
    logic [1:0]  quad;
    logic [30:0] z;
    assign sin_ang = (idx_reg[1] ? bam[1] : bam[0]) + (idx_reg[0] ? 32'h4000_0000 : 32'h0);
    assign quad    = sin_ang[31:30];
    assign z       = quad[0] ? (31'h4000_0000 - {1'b0, sin_ang[29:0]})
                             : {1'b0, sin_ang[29:0]};

    // operand magnitudes
    logic [16:0] diff_mag;
    logic signed [33:0] w_sel;
    logic signed [17:0] s_sel;
    logic [32:0] w_mag;
    logic [16:0] s_mag;
    logic signed [35:0] qi;
    logic [35:0] qi_mag;
    logic [29:0] tn_mag;
    logic [29:0] sec_mag;
    logic [16:0] s1_mag;
    logic [16:0] cmag;
    logic [47:0] d_mag;

    assign diff_mag = diff_reg[idx_reg][16] ? 17'(-diff_reg[idx_reg]) : 17'(diff_reg[idx_reg]);
    assign w_sel    = idx_reg[0] ? w_reg[2] : w_reg[1];
    assign s_sel    = (idx_reg == 2'd1 || idx_reg == 2'd2) ? sin_reg[1] : sin_reg[0];
    assign w_mag    = w_sel[33] ? 33'(-w_sel) : 33'(w_sel);
    assign s_mag    = s_sel[17] ? 17'(-s_sel) : 17'(s_sel);
    assign qi       = q_reg[51:16];
    assign qi_mag   = qi[35] ? 36'(-qi) : 36'(qi);
    assign tn_mag   = tn_reg[29] ? 30'(-tn_reg) : 30'(tn_reg);
    assign sec_mag  = sec_reg[29] ? 30'(-sec_reg) : 30'(sec_reg);
    assign s1_mag   = sin_reg[2][17] ? 17'(-sin_reg[2]) : 17'(sin_reg[2]);
    assign cmag     = sin_reg[3][17] ? 17'(-sin_reg[3]) : 17'(sin_reg[3]);
    assign d_mag    = d_reg[idx_reg][47] ? 48'(-d_reg[idx_reg]) : 48'(d_reg[idx_reg]);

    // shared multiplier operand select
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic        mul_neg;
    always_comb begin
        mul_a   = 64'd0;
        mul_b   = 32'd0;
        mul_neg = 1'b0;
        case (state_reg)
            ST_W: begin
                mul_a   = 64'(diff_mag);
                mul_b   = 32'(dt_reg);
                mul_neg = diff_reg[idx_reg][16];
            end
            ST_SIN: begin
                case (sub_reg)
                    3'd0: begin
                        mul_a = 64'(z);
                        mul_b = 32'(z);
                    end
                    3'd1: begin
                        mul_a = 64'(z2_reg);
                        mul_b = PC9;
                    end
                    3'd5: begin
                        mul_a = 64'(z);
                        mul_b = 32'(p_reg);
                    end
                    default: begin
                        mul_a = 64'(z2_reg);
                        mul_b = 32'(p_reg);
                    end
                endcase
            end
            ST_TAN: begin
                mul_a   = 64'(sec_mag);
                mul_b   = 32'(s1_mag);
                mul_neg = sec_reg[29] ^ sin_reg[2][17];
            end
            ST_QR: begin
                mul_a   = 64'(w_mag);
                mul_b   = 32'(s_mag);
                mul_neg = w_sel[33] ^ s_sel[17] ^ (idx_reg == 2'd3);
            end
            ST_QT: begin
                mul_a   = 64'(qi_mag);
                mul_b   = 32'(tn_mag);
                mul_neg = qi[35] ^ tn_reg[29];
            end
            ST_QS: begin
                mul_a   = 64'(qi_mag);
                mul_b   = 32'(sec_mag);
                mul_neg = qi[35] ^ sec_reg[29];
            end
            ST_SCALE: begin
                mul_a = 64'(d_mag);
                mul_b = RATE_MUL;
            end
            default: begin
                mul_a = 64'd0;
            end
        endcase
    end

    // 64x16 per cycle, low half first
    logic [15:0]        mul_b_half;
    logic [79:0]        pp;
    logic [95:0]        prod_mag;
    logic signed [96:0] prod_s;
    logic signed [96:0] prod_sh;
    assign mul_b_half = half_reg ? mul_b[31:16] : mul_b[15:0];
    assign pp         = 80'(mul_a) * 80'(mul_b_half);
    assign prod_mag   = acc_reg + {pp, 16'b0};
    assign prod_s     = mul_neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});
    assign prod_sh    = prod_s >>> 16;

    // sine rounding
    logic [33:0] v_rnd;
    logic [19:0] r_full;
    logic [16:0] r_clamp;
    logic signed [17:0] sin_new;
    assign v_rnd   = {1'b0, prod_mag[62:30]} + 34'd8192;
    assign r_full  = v_rnd[33:14];
    assign r_clamp = (r_full > 20'd65536) ? 17'd65536 : r_full[16:0];
    assign sin_new = quad[1] ? -$signed({1'b0, r_clamp}) : $signed({1'b0, r_clamp});

    // secant divider step, dividend 2^32
    logic [17:0] trial;
    logic        ge;
    logic [16:0] rem_new;
    logic [28:0] quo_new;
    assign trial   = {rem_reg, (cnt_reg == 6'd0)};
    assign ge      = trial >= {1'b0, cmag};
    assign rem_new = ge ? 17'(trial - {1'b0, cmag}) : trial[16:0];
    assign quo_new = {quo_reg[27:0], ge};

    // rate scaling and deadband
    logic [95:0]           res;
    logic                  res_gt;
    logic [ANGLE_BITS-1:0] delta;
    assign res    = prod_mag >> RATE_SHIFT;
    assign res_gt = res > {76'b0, deadband_reg};
    assign delta  = d_reg[idx_reg][47] ? ANGLE_BITS'(~res + 96'd1) : ANGLE_BITS'(res);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 2'd0;
            sub_reg      <= 3'd0;
            half_reg     <= 1'b0;
            cnt_reg      <= 6'd0;
            m_tvalid_reg <= 1'b0;
            deadband_reg <= DEADBAND_RST;
            for (int i = 0; i < 3; i++) begin
                att_reg[i] <= '0;
                off_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_OFFSET_X: off_reg[0]   <= cfg_data[15:0];
                    CFG_OFFSET_Y: off_reg[1]   <= cfg_data[15:0];
                    CFG_OFFSET_Z: off_reg[2]   <= cfg_data[15:0];
                    CFG_DEADBAND: deadband_reg <= cfg_data;
                    default: ;
                endcase
            end

            // the output step reloads the result itself
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        diff_reg[0] <= 17'(signed'(s_tdata[15:0])) - 17'(off_reg[0]);
                        diff_reg[1] <= 17'(signed'(s_tdata[31:16])) - 17'(off_reg[1]);
                        diff_reg[2] <= 17'(signed'(s_tdata[47:32])) - 17'(off_reg[2]);
                        dt_reg      <= s_tdata[63:48];
                        idx_reg     <= 2'd0;
                        half_reg    <= 1'b0;
                        state_reg   <= ST_W;
                    end
                end
                ST_DIV: begin
                    if (cnt_reg == 6'd0 && cmag < COS_SMALL) begin
                        // near vertical: saturate, zero cosine counts as positive
                        sec_reg   <= sin_reg[3][17] ? -$signed(SEC_MAX) : $signed(SEC_MAX);
                        state_reg <= ST_TAN;
                    end else if (cnt_reg == 6'd32) begin
                        sec_reg   <= sin_reg[3][17] ? -$signed({1'b0, quo_new})
                                                    : $signed({1'b0, quo_new});
                        state_reg <= ST_TAN;
                    end else begin
                        rem_reg <= rem_new;
                        quo_reg <= quo_new;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {bam[2], bam[1], bam[0]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    if (!half_reg) begin
                        acc_reg  <= {16'b0, pp};
                        half_reg <= 1'b1;
                    end else begin
                        half_reg <= 1'b0;
                        case (state_reg)
                            ST_W: begin
                                w_reg[idx_reg] <= prod_s[33:0];
                                if (idx_reg == 2'd2) begin
                                    idx_reg   <= 2'd0;
                                    sub_reg   <= 3'd0;
                                    state_reg <= ST_SIN;
                                end else begin
                                    idx_reg <= idx_reg + 2'd1;
                                end
                            end
                            ST_SIN: begin
                                if (sub_reg == 3'd0) begin
                                    z2_reg  <= prod_mag[60:30];
                                    sub_reg <= 3'd1;
                                end else if (sub_reg == 3'd5) begin
                                    sin_reg[idx_reg] <= sin_new;
                                    sub_reg          <= 3'd0;
                                    if (idx_reg == 2'd3) begin
                                        rem_reg   <= '0;
                                        quo_reg   <= '0;
                                        cnt_reg   <= 6'd0;
                                        state_reg <= ST_DIV;
                                    end else begin
                                        idx_reg <= idx_reg + 2'd1;
                                    end
                                end else begin
                                    p_reg   <= sin_coef(sub_reg) - prod_mag[60:30];
                                    sub_reg <= sub_reg + 3'd1;
                                end
                            end
                            ST_TAN: begin
                                tn_reg    <= prod_sh[29:0];
                                idx_reg   <= 2'd0;
                                state_reg <= ST_QR;
                            end
                            ST_QR: begin
                                case (idx_reg)
                                    2'd0:    q_reg <= prod_s[51:0];
                                    2'd1:    q_reg <= q_reg + prod_s[51:0];
                                    2'd2:    r_reg <= prod_s[51:0];
                                    default: r_reg <= r_reg + prod_s[51:0];
                                endcase
                                if (idx_reg == 2'd3) begin
                                    state_reg <= ST_QT;
                                end
                                idx_reg <= idx_reg + 2'd1;
                            end
                            ST_QT: begin
                                d_reg[0]  <= {{14{w_reg[0][33]}}, w_reg[0]} + prod_sh[47:0];
                                d_reg[1]  <= {{12{r_reg[51]}}, r_reg[51:16]};
                                state_reg <= ST_QS;
                            end
                            ST_QS: begin
                                d_reg[2]  <= prod_sh[47:0];
                                idx_reg   <= 2'd0;
                                state_reg <= ST_SCALE;
                            end
                            ST_SCALE: begin
                                if (res_gt) begin
                                    att_reg[idx_reg] <= att_reg[idx_reg] + delta;
                                end
                                if (idx_reg == 2'd2) begin
                                    state_reg <= ST_OUT;
                                end else begin
                                    idx_reg <= idx_reg + 2'd1;
                                end
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_W && !half_reg && idx_reg == 2'd0))
        else $error("accepted transaction did not start the sequence");

    a_sec_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAN) |-> (sec_mag <= SEC_MAX))
        else $error("secant beyond saturation");

    a_half_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> !(state_reg == ST_IDLE || state_reg == ST_DIV || state_reg == ST_OUT))
        else $error("multiplier phase set outside a multiply step");

endmodule
